// ===== rtl/rpa_pkg.sv =====
package rpa_pkg;

   localparam int PageW   = 15;
   localparam int CountW  = 8;
   localparam int CmdW    = 3;
   localparam int StatusW = 3;

   localparam logic [CmdW-1:0] CMD_ALLOCATE  = 3'd0;
   localparam logic [CmdW-1:0] CMD_FREE      = 3'd1;
   localparam logic [CmdW-1:0] CMD_INCREMENT = 3'd2;
   localparam logic [CmdW-1:0] CMD_QUERY     = 3'd3;
   localparam logic [CmdW-1:0] CMD_SEED      = 3'd4;

   localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK    = 3'd0,
      STATUS_EMPTY = 3'd1,
      STATUS_BAD   = 3'd2,
      STATUS_UNDER = 3'd3,
      STATUS_OVER  = 3'd4,
      STATUS_BUSY  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STACK,
      ST_COUNT
   } state_type;

endpackage

// ===== rtl/rpa_ram.sv =====
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/refcounted_page_allocator_core.sv =====
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      req_command, req_page_index
// rsp       out        rsp_valid / rsp_ready      rsp_page_out, rsp_count_out,
//                                                 rsp_page_freed, rsp_status
// csr       in         csr_write_enable           csr_write_data
//
// An allocate from a nonempty stack does a stack read, a count read and a
// count write; every other item skips the stack read. One item is in flight
// at a time. After reset a clearing pass zeroes the count memory; req_ready
// stays low meanwhile. A new transfer is taken while a result waits on rsp;
// the item then holds in ST_COUNT until the output slot frees.
module refcounted_page_allocator_core import rpa_pkg::*; #(
   parameter int NUM_PAGES = 32768
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CmdW-1:0]    req_command,
   input  logic [PageW-1:0]   req_page_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PageW-1:0]   rsp_page_out,
   output logic [CountW-1:0]  rsp_count_out,
   output logic               rsp_page_freed,
   output logic [StatusW-1:0] rsp_status,
   input  logic               csr_write_enable,
   input  logic [PageW-1:0]   csr_write_data
);

   localparam int AddrW  = $clog2(NUM_PAGES);
   localparam int DepthW = $clog2(NUM_PAGES + 1);

   state_type          state_ff, state_in;
   logic [AddrW-1:0]   clear_addr_ff, clear_addr_in;
   logic [PageW-1:0]   first_page_ff;
   logic [DepthW-1:0]  depth_ff, depth_in;
   logic [CmdW-1:0]    cmd_ff;
   logic [PageW-1:0]   page_ff, page_in;
   logic               bad_ff, empty_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PageW-1:0]   rsp_page_ff, rsp_page_in;
   logic [CountW-1:0]  rsp_count_ff, rsp_count_in;
   logic               rsp_freed_ff, rsp_freed_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               page_ok;
   logic               out_free;
   logic               stack_full;

   logic               cnt_wr_en, cnt_rd_en;
   logic [AddrW-1:0]   cnt_wr_addr, cnt_rd_addr;
   logic [CountW-1:0]  cnt_wr_data, cnt_rd_data;
   logic               stk_wr_en, stk_rd_en;
   logic [AddrW-1:0]   stk_wr_addr, stk_rd_addr;
   logic [PageW-1:0]   stk_rd_data;

   rpa_ram #(.WIDTH(CountW), .DEPTH(NUM_PAGES)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   rpa_ram #(.WIDTH(PageW), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (page_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stack_full = (depth_ff == DepthW'(NUM_PAGES));
   assign page_ok    = (req_page_index >= first_page_ff)
                    && ({17'd0, req_page_index} < 32'(NUM_PAGES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         first_page_ff <= '0;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            first_page_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         cmd_ff   <= req_command;
         bad_ff   <= !page_ok;
         empty_ff <= (depth_ff == '0);
      end
   end

   always_comb begin
      logic [CountW-1:0] cnt;
      logic              push;
      cnt            = cnt_rd_data;
      push           = 1'b0;
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      depth_in       = depth_ff;
      page_in        = page_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_page_in    = rsp_page_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_freed_in   = rsp_freed_ff;
      rsp_status_in  = rsp_status_ff;
      cnt_wr_en      = 1'b0;
      cnt_wr_addr    = AddrW'(page_ff);
      cnt_wr_data    = '0;
      cnt_rd_en      = 1'b0;
      cnt_rd_addr    = AddrW'(req_page_index);
      stk_wr_en      = 1'b0;
      stk_wr_addr    = AddrW'(depth_ff);
      stk_rd_en      = 1'b0;
      stk_rd_addr    = AddrW'(depth_ff - DepthW'(1));

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en     = 1'b1;
            cnt_wr_addr   = clear_addr_ff;
            clear_addr_in = clear_addr_ff + AddrW'(1);
            if (clear_addr_ff == AddrW'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               page_in = req_page_index;
               if (req_command == CMD_ALLOCATE) begin
                  if (depth_ff != '0) begin
                     stk_rd_en = 1'b1;
                     depth_in  = depth_ff - DepthW'(1);
                     state_in  = ST_STACK;
                  end else begin
                     state_in = ST_COUNT;
                  end
               end else begin
                  cnt_rd_en = 1'b1;
                  state_in  = ST_COUNT;
               end
            end
         end
         ST_STACK: begin
            page_in     = stk_rd_data;
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = AddrW'(stk_rd_data);
            state_in    = ST_COUNT;
         end
         ST_COUNT: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_page_in   = page_ff;
               rsp_count_in  = '0;
               rsp_freed_in  = 1'b0;
               rsp_status_in = STATUS_OK;
               if (cmd_ff == CMD_ALLOCATE) begin
                  if (empty_ff) begin
                     rsp_page_in   = '0;
                     rsp_status_in = STATUS_EMPTY;
                  end else if (cnt != '0) begin
                     rsp_count_in  = cnt;
                     rsp_status_in = STATUS_BUSY;
                  end else begin
                     cnt_wr_en    = 1'b1;
                     cnt_wr_data  = CountW'(1);
                     rsp_count_in = CountW'(1);
                  end
               end else if (cmd_ff inside {CMD_FREE, CMD_INCREMENT, CMD_QUERY, CMD_SEED}) begin
                  if (bad_ff) begin
                     rsp_status_in = STATUS_BAD;
                  end else begin
                     case (cmd_ff)
                        CMD_FREE: begin
                           if (cnt == '0) begin
                              rsp_status_in = STATUS_UNDER;
                           end else begin
                              cnt_wr_en    = 1'b1;
                              cnt_wr_data  = cnt - CountW'(1);
                              rsp_count_in = cnt - CountW'(1);
                              push         = (cnt == CountW'(1));
                           end
                        end
                        CMD_INCREMENT: begin
                           rsp_count_in = cnt;
                           if (cnt == COUNT_MAX) begin
                              rsp_status_in = STATUS_OVER;
                           end else begin
                              cnt_wr_en    = 1'b1;
                              cnt_wr_data  = cnt + CountW'(1);
                              rsp_count_in = cnt + CountW'(1);
                           end
                        end
                        CMD_SEED: begin
                           rsp_count_in = cnt;
                           push         = (cnt == '0);
                        end
                        default: begin
                           rsp_count_in = cnt;
                        end
                     endcase
                     if (push && !stack_full) begin
                        stk_wr_en    = 1'b1;
                        depth_in     = depth_ff + DepthW'(1);
                        rsp_freed_in = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_out   = rsp_page_ff;
   assign rsp_count_out  = rsp_count_ff;
   assign rsp_page_freed = rsp_freed_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
